// ----- design/tpp_pkg.sv -----
// Shared types, constants and character codes for the tablet packet parser.
// No dependencies; every design file imports this package.
package tpp_pkg;

  localparam int NUM_WIDTH        = 16;
  localparam int MAX_PACKET_BYTES = 30;
  localparam int CNT_W            = $clog2(MAX_PACKET_BYTES + 1);
  localparam int VI_W             = 2;
  localparam int POS_W            = 16;
  localparam int BTN_W            = 8;
  localparam int PRESS_W          = 8;
  localparam int OFS_W            = 8;
  localparam int THR_W            = 5;
  localparam int P_W              = 8;
  localparam int DIFF_W           = P_W + 2;
  localparam int DIV_W            = 16;
  localparam int DEN_W            = 8;
  localparam int DIV_CNT_W        = $clog2(DIV_W);
  localparam int APB_AW           = 4;
  localparam int APB_DW           = 32;
  localparam int REG_IDX_W        = 2;

  localparam logic [NUM_WIDTH-1:0] NUM_CAP     = {1'b1, {(NUM_WIDTH-1){1'b0}}};
  localparam logic [NUM_WIDTH-1:0] NUM_POS_MAX = {1'b0, {(NUM_WIDTH-1){1'b1}}};

  localparam int POS_MAX   = 32767;
  localparam int POS_MIN   = -32768;
  localparam int T_LIMIT   = 99;
  localparam int PRESS_TOP = 255;

  localparam logic [VI_W-1:0] VI_LAST = 2'd2;

  localparam logic [OFS_W-1:0]   X_OFFSET_RST  = 8'd30;
  localparam logic [OFS_W-1:0]   Y_OFFSET_RST  = 8'd40;
  localparam logic [THR_W-1:0]   THRESHOLD_RST = 5'd5;
  localparam logic signed [P_W-1:0] PMIN_RST   = -8'sd10;
  localparam logic signed [P_W-1:0] PMAX_RST   = 8'sd10;

  // register indexes (byte address 4*i)
  localparam logic [REG_IDX_W-1:0] REG_X_OFFSET  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_Y_OFFSET  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 2'd2;

  localparam logic [7:0] CH_PSTYLUS = 8'h21; // '!'
  localparam logic [7:0] CH_STYLUS  = 8'h23; // '#'
  localparam logic [7:0] CH_PUCK    = 8'h2A; // '*'
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;

  typedef enum logic [2:0] {
    PH_TYPE,
    PH_SEEK,
    PH_START,
    PH_DIGITS,
    PH_TAIL
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PSTYLUS,
    KIND_PUCK,
    KIND_STYLUS,
    KIND_BAD
  } kind_e;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_FIN,
    SEQ_PREP,
    SEQ_DIV,
    SEQ_DONE
  } seq_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       rx_error;
    logic       alt_key;
  } in_item_t;

  typedef struct packed {
    logic                    ok;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [BTN_W-1:0]        buttons;
    logic [PRESS_W-1:0]      pressure_out;
    logic                    pressure_capable;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } div_req_t;

endpackage

// ----- design/tpp_div.sv -----
// Restoring divider, one quotient bit per cycle, used for pressure scaling.
// Depends on tpp_pkg for widths and the request struct.
module tpp_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tpp_pkg::div_req_t       req_i,
  output logic                    done_o,
  output logic [tpp_pkg::DIV_W-1:0] quot_o
);
  import tpp_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DEN_W:0]       rem_q, rem_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [DEN_W-1:0]     den_q, den_d;
  logic [DEN_W+1:0]     shifted;
  logic [DEN_W+1:0]     trial;

  assign shifted = {rem_q, quo_q[DIV_W-1]};
  assign trial   = shifted - {2'b00, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      den_d  = req_i.divisor;
    end else if (busy_q) begin
      if (shifted >= {2'b00, den_q}) begin
        rem_d = trial[DEN_W:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[DEN_W:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ----- design/tablet_packet_parser.sv -----
// Tablet packet parser top: byte parser, end-of-packet sequencer, APB registers.
// Depends on tpp_pkg and tpp_div (iterative divider).
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_valid_i, in_stall_o, in_data_i    | byte in
//  out     | out_valid_o, out_stall_i, out_data_o | result out
//  cfg     | psel, penable, pwrite, paddr, pwdata | APB regs
//
// A byte that does not end a packet leaves the sequencer idle; a receive error goes
// to the emit step. A packet end goes through the finish and emit steps; a pressure
// stylus packet with its third value in range adds a prepare step and, when it divides, the 16-step divider.
// in_stall_o is high while the sequencer runs; the last step waits when the
// output register holds an untaken transaction. Reset is asynchronous, low.
module tablet_packet_parser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  tpp_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output tpp_pkg::out_item_t           out_data_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tpp_pkg::APB_AW-1:0]   paddr,
  input  logic [tpp_pkg::APB_DW-1:0]   pwdata,
  output logic [tpp_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import tpp_pkg::*;

  seq_e                    seq_q, seq_d;
  phase_e                  phase_q, phase_d;
  kind_e                   kind_q, kind_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [VI_W-1:0]         vi_q, vi_d;
  logic                    neg_q, neg_d;
  logic [NUM_WIDTH-1:0]    accum_q, accum_d;
  logic signed [NUM_WIDTH-1:0] raw_x_q, raw_x_d, raw_y_q, raw_y_d;
  logic signed [P_W-1:0]   pmin_q, pmin_d, pmax_q, pmax_d, p_q, p_d;
  logic signed [POS_W-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [BTN_W-1:0]        cur_btn_q, cur_btn_d;
  logic [PRESS_W-1:0]      cur_press_q, cur_press_d;
  logic                    cur_cap_q, cur_cap_d;
  logic                    ok_q, ok_d;
  logic                    alt_q, alt_d;
  logic                    out_valid_q, out_valid_d;
  out_item_t               out_q, out_d;
  logic [OFS_W-1:0]        xoff_q, yoff_q;
  logic [THR_W-1:0]        thr_q;

  logic                    in_acc;
  logic [7:0]              ch;
  logic                    is_digit, is_space;
  logic [NUM_WIDTH+3:0]    acc_mul;
  logic [NUM_WIDTH-1:0]    acc_sat;
  logic signed [NUM_WIDTH-1:0] num_val;
  logic signed [NUM_WIDTH:0]   dx, dy;
  logic signed [POS_W-1:0] nx, ny;
  logic                    t_in_range, t_is_top;
  logic signed [P_W-1:0]   p_new;
  logic                    complete;
  logic signed [DIFF_W-1:0] diff_p, den_p;
  logic [DIV_W-1:0]        num_p;
  logic [PRESS_W-1:0]      q_clamped;
  div_req_t                div_req;
  logic                    div_done;
  logic [DIV_W-1:0]        div_quot;
  logic                    wr_en;
  logic [REG_IDX_W-1:0]    reg_idx;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [NUM_WIDTH:0] v);
    logic signed [POS_W-1:0] r;
    if (v > POS_MAX) r = POS_W'(POS_MAX);
    else if (v < POS_MIN) r = POS_W'(POS_MIN);
    else r = POS_W'(v);
    return r;
  endfunction

  tpp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign in_stall_o = (seq_q != SEQ_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign ch         = in_data_i.rx_byte;
  assign is_digit   = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_space   = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));

  // accum * 10 + digit, saturated at the magnitude cap
  assign acc_mul = {1'b0, accum_q, 3'b000} + {3'b000, accum_q, 1'b0}
                   + (NUM_WIDTH+4)'(ch[3:0]);
  assign acc_sat = (acc_mul > (NUM_WIDTH+4)'(NUM_CAP)) ? NUM_CAP : acc_mul[NUM_WIDTH-1:0];

  assign num_val = neg_q ? $signed(-accum_q)
                 : $signed((accum_q > NUM_POS_MAX) ? NUM_POS_MAX : accum_q);

  assign dx = {raw_x_q[NUM_WIDTH-1], raw_x_q} - $signed((NUM_WIDTH+1)'(xoff_q));
  assign dy = {raw_y_q[NUM_WIDTH-1], raw_y_q} - $signed((NUM_WIDTH+1)'(yoff_q));
  assign nx = sat_pos(dx);
  assign ny = sat_pos(dy);

  assign t_in_range = (num_val > -T_LIMIT) && (num_val < T_LIMIT);
  assign t_is_top   = (num_val == T_LIMIT);
  assign p_new      = num_val[P_W-1:0];

  assign complete = (phase_q == PH_TAIL) ||
                    (((phase_q == PH_START) || (phase_q == PH_DIGITS)) && (vi_q == VI_LAST));

  assign diff_p = DIFF_W'(p_q) - DIFF_W'(pmin_q) - $signed(DIFF_W'(thr_q));
  assign den_p  = DIFF_W'(pmax_q) - DIFF_W'(pmin_q) - $signed(DIFF_W'(thr_q));
  // diff * 255 as (diff << 8) - diff
  assign num_p  = {diff_p[P_W-1:0], 8'h00} - {8'h00, diff_p[P_W-1:0]};

  assign q_clamped = (div_quot > DIV_W'(PRESS_TOP)) ? PRESS_W'(PRESS_TOP)
                   : (div_quot == '0) ? PRESS_W'(1) : div_quot[PRESS_W-1:0];

  always_comb begin
    logic end_val;
    logic end_comma;
    end_val     = 1'b0;
    end_comma   = 1'b0;
    seq_d       = seq_q;
    phase_d     = phase_q;
    kind_d      = kind_q;
    cnt_d       = cnt_q;
    vi_d        = vi_q;
    neg_d       = neg_q;
    accum_d     = accum_q;
    raw_x_d     = raw_x_q;
    raw_y_d     = raw_y_q;
    pmin_d      = pmin_q;
    pmax_d      = pmax_q;
    p_d         = p_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    cur_btn_d   = cur_btn_q;
    cur_press_d = cur_press_q;
    cur_cap_d   = cur_cap_q;
    ok_d        = ok_q;
    alt_d       = alt_q;
    div_req     = '0;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (seq_q)
      SEQ_IDLE: begin
        if (in_acc) begin
          if (in_data_i.rx_error) begin
            phase_d = PH_TYPE;
            cnt_d   = '0;
            vi_d    = '0;
            ok_d    = 1'b0;
            seq_d   = SEQ_DONE;
          end else begin
            cnt_d = cnt_q + 1'b1;
            unique case (phase_q)
              PH_TYPE: begin
                if (ch == CH_PSTYLUS) kind_d = KIND_PSTYLUS;
                else if (ch == CH_PUCK) kind_d = KIND_PUCK;
                else if (ch == CH_STYLUS) kind_d = KIND_STYLUS;
                else kind_d = KIND_BAD;
                vi_d    = '0;
                phase_d = PH_SEEK;
              end
              PH_SEEK: begin
                if (ch == CH_COMMA) begin
                  phase_d = PH_START;
                  accum_d = '0;
                  neg_d   = 1'b0;
                end
              end
              PH_START: begin
                if (is_digit) begin
                  accum_d = NUM_WIDTH'(ch[3:0]);
                  phase_d = PH_DIGITS;
                end else if ((ch == CH_MINUS) || (ch == CH_PLUS)) begin
                  neg_d   = (ch == CH_MINUS);
                  phase_d = PH_DIGITS;
                end else if (!is_space) begin
                  end_val   = 1'b1;
                  end_comma = (ch == CH_COMMA);
                end
              end
              PH_DIGITS: begin
                if (is_digit) begin
                  accum_d = acc_sat;
                end else begin
                  end_val   = 1'b1;
                  end_comma = (ch == CH_COMMA);
                end
              end
              PH_TAIL: begin
              end
              default: phase_d = PH_TYPE;
            endcase
            if (end_val) begin
              if (vi_q >= VI_LAST) begin
                phase_d = PH_TAIL;
              end else begin
                if (vi_q == '0) raw_x_d = num_val;
                else raw_y_d = num_val;
                vi_d = vi_q + 1'b1;
                if (end_comma) begin
                  phase_d = PH_START;
                  accum_d = '0;
                  neg_d   = 1'b0;
                end else begin
                  phase_d = PH_SEEK;
                end
              end
            end
            alt_d = in_data_i.alt_key;
            if ((ch == CH_NL) || (cnt_d >= CNT_W'(MAX_PACKET_BYTES))) seq_d = SEQ_FIN;
          end
        end
      end
      SEQ_FIN: begin
        phase_d = PH_TYPE;
        cnt_d   = '0;
        vi_d    = '0;
        ok_d    = 1'b0;
        seq_d   = SEQ_DONE;
        if ((kind_q != KIND_BAD) && complete) begin
          ok_d      = 1'b1;
          cur_cap_d = 1'b0;
          unique case (kind_q)
            KIND_PSTYLUS: begin
              cur_cap_d = 1'b1;
              cur_btn_d = {6'b0, alt_q, 1'b0};
              if (t_in_range) begin
                cur_x_d = nx;
                cur_y_d = ny;
                p_d     = p_new;
                if (p_new < pmin_q) pmin_d = p_new;
                if (p_new > pmax_q) pmax_d = p_new;
                seq_d   = SEQ_PREP;
              end
            end
            KIND_STYLUS: begin
              if (!t_is_top) begin
                cur_x_d   = nx;
                cur_y_d   = ny;
                cur_btn_d = num_val[BTN_W-1:0];
              end
            end
            KIND_PUCK: begin
              cur_btn_d = '0;
              if (!t_is_top) begin
                cur_x_d   = nx;
                cur_y_d   = ny;
                cur_btn_d = {6'b0, num_val[2], num_val[1]};
              end
            end
            KIND_BAD: begin
            end
            default: ok_d = 1'b0;
          endcase
        end
      end
      SEQ_PREP: begin
        seq_d = SEQ_DONE;
        if (diff_p >= 0) begin
          if (den_p > 0) begin
            div_req.start    = 1'b1;
            div_req.dividend = num_p;
            div_req.divisor  = den_p[DEN_W-1:0];
            seq_d            = SEQ_DIV;
          end else begin
            cur_press_d = PRESS_W'(1);
            cur_btn_d   = {6'b0, alt_q, 1'b1};
          end
        end
      end
      SEQ_DIV: begin
        if (div_done) begin
          cur_press_d = q_clamped;
          cur_btn_d   = {6'b0, alt_q, 1'b1};
          seq_d       = SEQ_DONE;
        end
      end
      SEQ_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d            = 1'b1;
          out_d.ok               = ok_q;
          out_d.pos_x            = cur_x_q;
          out_d.pos_y            = cur_y_q;
          out_d.buttons          = cur_btn_q;
          out_d.pressure_out     = cur_press_q;
          out_d.pressure_capable = cur_cap_q;
          seq_d                  = SEQ_IDLE;
        end
      end
      default: seq_d = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= SEQ_IDLE;
      phase_q     <= PH_TYPE;
      kind_q      <= KIND_PSTYLUS;
      cnt_q       <= '0;
      vi_q        <= '0;
      neg_q       <= 1'b0;
      accum_q     <= '0;
      raw_x_q     <= '0;
      raw_y_q     <= '0;
      pmin_q      <= PMIN_RST;
      pmax_q      <= PMAX_RST;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      cur_btn_q   <= '0;
      cur_press_q <= '0;
      cur_cap_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      seq_q       <= seq_d;
      phase_q     <= phase_d;
      kind_q      <= kind_d;
      cnt_q       <= cnt_d;
      vi_q        <= vi_d;
      neg_q       <= neg_d;
      accum_q     <= accum_d;
      raw_x_q     <= raw_x_d;
      raw_y_q     <= raw_y_d;
      pmin_q      <= pmin_d;
      pmax_q      <= pmax_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      cur_btn_q   <= cur_btn_d;
      cur_press_q <= cur_press_d;
      cur_cap_q   <= cur_cap_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q   <= p_d;
    ok_q  <= ok_d;
    alt_q <= alt_d;
    out_q <= out_d;
  end

  // APB register file
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[APB_AW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xoff_q <= X_OFFSET_RST;
      yoff_q <= Y_OFFSET_RST;
      thr_q  <= THRESHOLD_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_X_OFFSET:  xoff_q <= pwdata[OFS_W-1:0];
        REG_Y_OFFSET:  yoff_q <= pwdata[OFS_W-1:0];
        REG_THRESHOLD: thr_q  <= pwdata[THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_X_OFFSET:  prdata = APB_DW'(xoff_q);
      REG_Y_OFFSET:  prdata = APB_DW'(yoff_q);
      REG_THRESHOLD: prdata = APB_DW'(thr_q);
      default:       prdata = '0;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // receive error goes straight to the emit step as a failure
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.rx_error |=> (seq_q == SEQ_DONE) && !ok_q)
    else $error("receive error did not reach emit step as failure");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (seq_q == SEQ_DIV))
    else $error("divider finished outside its sequencer step");

  // pen down from the pressure stylus always carries a nonzero pressure
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.ok && out_data_o.pressure_capable && out_data_o.buttons[0]
    |-> (out_data_o.pressure_out != '0))
    else $error("pen down with zero pressure");

endmodule

// ----- sim/tb_tablet_packet_parser.sv -----
// Self-checking bench for tablet_packet_parser: feeds ASCII report bytes, programs the
// offset/threshold registers over APB, and checks every report against an in-bench tracker.
// Depends on tpp_pkg and the design sources; reads no files.
`timescale 1ns / 1ps

module tb_tablet_packet_parser;
  import tpp_pkg::*;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_BYTES  = 1000;
  localparam int RANDOM_PHASES = 6;
  localparam int MAG_CAP       = 1 << (NUM_WIDTH - 1);
  localparam logic [BTN_W-1:0] BTN_LEFT  = 8'h01;
  localparam logic [BTN_W-1:0] BTN_RIGHT = 8'h02;
  localparam string JUNK = "abcqxyzXYZ:;/";

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  in_item_t          in_data_i;
  logic              out_valid_o;
  logic              out_stall_i;
  out_item_t         out_data_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  tablet_packet_parser dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------
  // Report tracker: mirrors the parser state byte by byte
  // ---------------------------------------------------------------
  logic [OFS_W-1:0]   cfg_xofs, cfg_yofs;
  logic [THR_W-1:0]   cfg_thr;
  int                 trk_count, trk_vidx, trk_mag, trk_rawx, trk_rawy;
  int                 trk_pmin, trk_pmax, trk_posx, trk_posy;
  phase_e             trk_phase;
  kind_e              trk_kind;
  bit                 trk_neg;
  logic [BTN_W-1:0]   trk_btns;
  logic [PRESS_W-1:0] trk_press;
  bit                 trk_capable;

  out_item_t  pending_reports[$];
  logic [7:0] pkt_bytes[$];

  int  fail_count, cycle_count, bytes_sent, reports_checked, fail_reports, settings_used;
  bit  in_gaps, out_gaps, err_inject;

  function automatic void restart_packet();
    trk_count = 0;
    trk_phase = PH_TYPE;
    trk_vidx  = 0;
  endfunction

  function automatic void reset_tracker();
    cfg_xofs    = X_OFFSET_RST;
    cfg_yofs    = Y_OFFSET_RST;
    cfg_thr     = THRESHOLD_RST;
    restart_packet();
    trk_kind    = KIND_PSTYLUS;
    trk_neg     = 1'b0;
    trk_mag     = 0;
    trk_rawx    = 0;
    trk_rawy    = 0;
    trk_pmin    = int'(PMIN_RST);
    trk_pmax    = int'(PMAX_RST);
    trk_posx    = 0;
    trk_posy    = 0;
    trk_btns    = '0;
    trk_press   = '0;
    trk_capable = 1'b0;
  endfunction

  function automatic int signed_value();
    if (trk_neg) return -trk_mag;
    return (trk_mag > MAG_CAP - 1) ? MAG_CAP - 1 : trk_mag;
  endfunction

  function automatic int clamp16(int v);
    if (v > POS_MAX) return POS_MAX;
    if (v < POS_MIN) return POS_MIN;
    return v;
  endfunction

  function automatic void begin_value();
    trk_phase = PH_START;
    trk_mag   = 0;
    trk_neg   = 1'b0;
  endfunction

  // a comma that closes a value also opens the next one
  function automatic void close_value(bit comma);
    if (trk_vidx >= VI_LAST) begin
      trk_phase = PH_TAIL;
      return;
    end
    if (trk_vidx == 0) trk_rawx = signed_value();
    else trk_rawy = signed_value();
    trk_vidx++;
    if (comma) begin_value();
    else trk_phase = PH_SEEK;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit packet_done(logic alt);
    int t, nx, ny, num, den, q;
    bit complete;
    complete = trk_phase == PH_TAIL ||
      ((trk_phase == PH_START || trk_phase == PH_DIGITS) && trk_vidx == VI_LAST);
    if (trk_kind == KIND_BAD || !complete) return 1'b0;
    t  = signed_value();
    nx = clamp16(trk_rawx - int'(cfg_xofs));
    ny = clamp16(trk_rawy - int'(cfg_yofs));
    trk_capable = 1'b0;
    case (trk_kind)
      KIND_PSTYLUS: begin
        trk_btns    = '0;
        trk_capable = 1'b1;
        if (t > -T_LIMIT && t < T_LIMIT) begin
          trk_posx = nx;
          trk_posy = ny;
          if (t < trk_pmin) trk_pmin = t;
          if (t > trk_pmax) trk_pmax = t;
          if (t >= trk_pmin + int'(cfg_thr)) begin
            num = (t - trk_pmin - int'(cfg_thr)) * PRESS_TOP;
            den = trk_pmax - trk_pmin - int'(cfg_thr);
            q   = (den > 0) ? num / den : 1;
            if (q > PRESS_TOP) q = PRESS_TOP;
            if (q < 1) q = 1;
            trk_btns  = BTN_LEFT;
            trk_press = q[PRESS_W-1:0];
          end
        end
        if (alt) trk_btns |= BTN_RIGHT;
      end
      KIND_STYLUS: begin
        if (t != T_LIMIT) begin
          trk_posx = nx;
          trk_posy = ny;
          trk_btns = t[BTN_W-1:0];
        end
      end
      default: begin
        trk_btns = '0;
        if (t != T_LIMIT) begin
          trk_posx = nx;
          trk_posy = ny;
          if (t[1]) trk_btns |= BTN_LEFT;
          if (t[2]) trk_btns |= BTN_RIGHT;
        end
      end
    endcase
    return 1'b1;
  endfunction

  function automatic out_item_t current_report(bit ok_bit);
    out_item_t r;
    r.ok               = ok_bit;
    r.pos_x            = trk_posx[POS_W-1:0];
    r.pos_y            = trk_posy[POS_W-1:0];
    r.buttons          = trk_btns;
    r.pressure_out     = trk_press;
    r.pressure_capable = trk_capable;
    return r;
  endfunction

  // returns 1 when the byte closes a packet (or is a receive error) and fills rep
  function automatic bit predict_report_byte(in_item_t it, output out_item_t rep);
    logic [7:0] c;
    bit accepted;
    c = it.rx_byte;
    if (it.rx_error) begin
      restart_packet();
      rep = current_report(1'b0);
      return 1'b1;
    end
    trk_count++;
    case (trk_phase)
      PH_TYPE: begin
        case (c)
          CH_PSTYLUS: trk_kind = KIND_PSTYLUS;
          CH_PUCK:    trk_kind = KIND_PUCK;
          CH_STYLUS:  trk_kind = KIND_STYLUS;
          default:    trk_kind = KIND_BAD;
        endcase
        trk_vidx  = 0;
        trk_phase = PH_SEEK;
      end
      PH_SEEK: begin
        if (c == CH_COMMA) begin_value();
      end
      PH_START: begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          trk_mag   = int'(c - CH_ZERO);
          trk_phase = PH_DIGITS;
        end else if (c == CH_MINUS || c == CH_PLUS) begin
          trk_neg   = (c == CH_MINUS);
          trk_phase = PH_DIGITS;
        end else if (!is_blank(c)) begin
          close_value(c == CH_COMMA);
        end
      end
      PH_DIGITS: begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          trk_mag = trk_mag * 10 + int'(c - CH_ZERO);
          if (trk_mag > MAG_CAP) trk_mag = MAG_CAP;
        end else begin
          close_value(c == CH_COMMA);
        end
      end
      default: ;
    endcase
    if (c != CH_NL && trk_count < MAX_PACKET_BYTES) return 1'b0;
    accepted = packet_done(it.alt_key);
    restart_packet();
    rep = current_report(accepted);
    return 1'b1;
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  // ---------------------------------------------------------------
  // Output side: random stall and report checking
  // ---------------------------------------------------------------
  always @(negedge clk_i) out_stall_i <= out_gaps && ($urandom_range(0, 99) < 6);

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_reports.size() == 0) begin
        note_failure($sformatf("cycle %0d: report with no transaction pending, got %p",
                               cycle_count, out_data_o));
      end else begin
        want = pending_reports.pop_front();
        reports_checked++;
        if (out_data_o.ok !== want.ok || out_data_o.pos_x !== want.pos_x ||
            out_data_o.pos_y !== want.pos_y || out_data_o.buttons !== want.buttons ||
            out_data_o.pressure_out !== want.pressure_out ||
            out_data_o.pressure_capable !== want.pressure_capable) begin
          note_failure($sformatf(
            "cycle %0d report %0d: want ok=%0b x=%0d y=%0d btn=%02h p=%0d cap=%0b, got ok=%0b x=%0d y=%0d btn=%02h p=%0d cap=%0b",
            cycle_count, reports_checked, want.ok, want.pos_x, want.pos_y, want.buttons,
            want.pressure_out, want.pressure_capable, out_data_o.ok, out_data_o.pos_x,
            out_data_o.pos_y, out_data_o.buttons, out_data_o.pressure_out,
            out_data_o.pressure_capable));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports outstanding", cycle_count,
               pending_reports.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // Input side and register port
  // ---------------------------------------------------------------
  task automatic send_byte(logic [7:0] c, logic err, logic alt);
    in_item_t  item;
    out_item_t rep;
    item.rx_byte  = c;
    item.rx_error = err;
    item.alt_key  = alt;
    @(negedge clk_i);
    while (in_gaps && $urandom_range(0, 99) < 6) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
    if (predict_report_byte(item, rep)) begin
      pending_reports.push_back(rep);
      if (!rep.ok) fail_reports++;
    end
  endtask

  task automatic send_text(string s, logic alt);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0, alt);
  endtask

  // drop valid, wait for every pending report, then give the sequencer time to go idle
  task automatic settle_block();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [APB_DW-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_X_OFFSET:  cfg_xofs = val[OFS_W-1:0];
      REG_Y_OFFSET:  cfg_yofs = val[OFS_W-1:0];
      REG_THRESHOLD: cfg_thr  = val[THR_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_register(logic [REG_IDX_W-1:0] idx);
    logic [APB_DW-1:0] got, want;
    case (idx)
      REG_X_OFFSET:  want = APB_DW'(cfg_xofs);
      REG_Y_OFFSET:  want = APB_DW'(cfg_yofs);
      default:       want = APB_DW'(cfg_thr);
    endcase
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    got = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want)
      note_failure($sformatf("register %0d read back %h, want %h", idx, got, want));
  endtask

  task automatic apply_config(logic [OFS_W-1:0] xo, logic [OFS_W-1:0] yo,
                              logic [THR_W-1:0] thr);
    settle_block();
    apb_write(REG_X_OFFSET, APB_DW'(xo));
    apb_write(REG_Y_OFFSET, APB_DW'(yo));
    apb_write(REG_THRESHOLD, APB_DW'(thr));
    check_register(REG_X_OFFSET);
    check_register(REG_Y_OFFSET);
    check_register(REG_THRESHOLD);
    settings_used++;
  endtask

  // ---------------------------------------------------------------
  // Random report builder
  // ---------------------------------------------------------------
  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++) pkt_bytes.push_back(s[i]);
  endtask

  task automatic queue_value(int v);
    string s;
    s = $sformatf("%0d", v);
    if (v >= 0 && $urandom_range(0, 7) == 0) s = {"+", s};
    if ($urandom_range(0, 7) == 0) s = {" ", s};
    if ($urandom_range(0, 19) != 0) queue_text(s);
  endtask

  task automatic queue_junk();
    repeat ($urandom_range(1, 2)) pkt_bytes.push_back(JUNK[$urandom_range(0, JUNK.len() - 1)]);
  endtask

  function automatic int pick_coord();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return int'($urandom_range(0, 3000));
    if (roll < 80) return -int'($urandom_range(0, 3000));
    if (roll < 90) return int'($urandom_range(30000, 99999));
    return -int'($urandom_range(30000, 99999));
  endfunction

  function automatic int pick_third(logic [7:0] kind_ch);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return $urandom_range(0, 1) ? T_LIMIT : -T_LIMIT;
    if (roll < 16) return pick_coord();
    case (kind_ch)
      CH_PSTYLUS: return int'($urandom_range(0, 2 * T_LIMIT - 2)) - (T_LIMIT - 1);
      CH_PUCK:    return int'($urandom_range(0, 15));
      default:    return int'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic build_random_report();
    int roll, pos;
    logic [7:0] kind_ch;
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      repeat ($urandom_range(1, 40)) pkt_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    roll = $urandom_range(0, 99);
    if (roll < 35) kind_ch = CH_PSTYLUS;
    else if (roll < 60) kind_ch = CH_PUCK;
    else if (roll < 85) kind_ch = CH_STYLUS;
    else kind_ch = 8'($urandom_range(0, 255));
    pkt_bytes.push_back(kind_ch);
    if ($urandom_range(0, 3) == 0) queue_junk();
    pkt_bytes.push_back(CH_COMMA);
    queue_value(pick_coord());
    pkt_bytes.push_back(CH_COMMA);
    queue_value(pick_coord());
    pkt_bytes.push_back(CH_COMMA);
    queue_value(pick_third(kind_ch));
    if ($urandom_range(0, 4) == 0) queue_junk();
    pkt_bytes.push_back(CH_NL);
    // a minority of broken reports: lost byte, corrupted byte, or no terminator
    roll = $urandom_range(0, 99);
    pos  = $urandom_range(0, pkt_bytes.size() - 1);
    if (roll < 5) begin
      pkt_bytes.delete(pos);
    end else if (roll < 10) begin
      pkt_bytes[pos] = 8'($urandom_range(0, 255));
    end else if (roll < 14) begin
      void'(pkt_bytes.pop_back());
      repeat ($urandom_range(0, 14)) pkt_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_report();
    for (int i = 0; i < pkt_bytes.size(); i++) begin
      if (err_inject && $urandom_range(0, 99) < 2)
        send_byte(8'($urandom_range(0, 255)), 1'b1, 1'($urandom_range(0, 1)));
      send_byte(pkt_bytes[i], 1'b0, 1'($urandom_range(0, 1)));
    end
    pkt_bytes.delete();
  endtask

  // ---------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------
  task automatic test_reset_registers();
    check_register(REG_X_OFFSET);
    check_register(REG_Y_OFFSET);
    check_register(REG_THRESHOLD);
  endtask

  task automatic test_report_kinds();
    send_text("!,10,20,0\n", 1'b0);
    send_text("!,-5,7,60\n", 1'b1);
    send_text("!,3,4,-98\n", 1'b0);
    send_text("!,1,2,99\n", 1'b1);
    send_text("!,1,2,-99\n", 1'b0);
    send_text("#,100,200,3\n", 1'b0);
    send_text("#,5,5,-1\n", 1'b1);
    send_text("#,6,6,99\n", 1'b0);
    send_text("*,300,400,6\n", 1'b1);
    send_text("*,7,8,99\n", 1'b0);
    send_text("?,1,2,3\n", 1'b0);
  endtask

  task automatic test_number_parsing();
    send_text("#ab, +12 ,\t-34x,7yz\n", 1'b0);
    send_text("#,,,\n", 1'b1);
    send_text("*,99999,-99999,2\n", 1'b0);
    send_text("#,-32768,32767,300\n", 1'b0);
    // no terminator: the length limit closes the packet mid-number
    send_text("#,1,2,3", 1'b1);
    repeat (MAX_PACKET_BYTES - 7) send_text("7", 1'b1);
  endtask

  task automatic test_failures();
    send_text("#,1,2\n", 1'b0);
    send_text("!12 34 56\n", 1'b1);
    send_text("!,1,", 1'b0);
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'h00, 1'b1, 1'b1);
    send_text("*,4,5,2\n", 1'b1);
    send_text("\n", 1'b0);
  endtask

  task automatic test_offsets_and_threshold();
    apply_config('0, '0, '0);
    send_text("!,-5,-5,-98\n", 1'b0);
    send_text("!,0,0,98\n", 1'b1);
    send_text("*,0,0,4\n", 1'b0);
    apply_config('1, '1, '1);
    send_text("!,-32768,10,0\n", 1'b0);
    send_text("!,40,40,98\n", 1'b0);
    send_text("#,0,0,0\n", 1'b1);
    apply_config(X_OFFSET_RST, Y_OFFSET_RST, THRESHOLD_RST);
  endtask

  task automatic test_random_traffic();
    int base;
    base = bytes_sent;
    err_inject = 1'b1;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       apply_config('0, '0, '0);
        1:       apply_config('1, '1, '1);
        default: apply_config(OFS_W'($urandom_range(0, 255)), OFS_W'($urandom_range(0, 255)),
                              THR_W'($urandom_range(0, 31)));
      endcase
      // one phase runs back to back on both sides
      in_gaps  = (ph != 3);
      out_gaps = (ph != 3);
      while (bytes_sent - base < (ph + 1) * RANDOM_BYTES / RANDOM_PHASES) begin
        build_random_report();
        send_report();
      end
    end
    in_gaps    = 1'b1;
    out_gaps   = 1'b1;
    err_inject = 1'b0;
  endtask

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_gaps     = 1'b1;
    out_gaps    = 1'b1;
    err_inject  = 1'b0;
    reset_tracker();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_registers();
    test_report_kinds();
    test_number_parsing();
    test_failures();
    test_offsets_and_threshold();
    test_random_traffic();
    settle_block();

    $display("Sent %0d report bytes over %0d register settings; %0d reports checked,",
             bytes_sent, settings_used, reports_checked);
    $display("%0d of them rejected packets or receive errors, %0d mismatches.",
             fail_reports, fail_count);
    if (fail_count == 0 && pending_reports.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
